@@ hdl/t5ks_pkg.sv @@
// Shared types and constants for the top-five tracker with key search.
// Holds the sequencer state type, the action codes and the fixed field widths.
// Depends on nothing.
package t5ks_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int TOP_FIELDS = 5;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ hdl/top5_tracker_with_key_search.sv @@
// Top level of the top-five tracker with key search.
// Holds the value store, the top list, the search sequencer and the output register.
// Depends on t5ks_pkg.

// An append word writes the next store entry and folds the value into the sorted
// top list, unless the store is full. A search word walks the held entries through
// the store's single read port, one entry per cycle unless a second match waits
// on a stalled output, and compares each with the key in one shared comparator.
// Its final result goes from the done state to the output register once the
// output is free, and the next word is taken in the cycle after that. A match is
// held back until the next one is found, so the final result can carry last. The
// block takes no new word until a search has handed over its final result to
// the output register; that register then lets the next word in while it waits.
module top5_tracker_with_key_search
    import t5ks_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int TOP_COUNT = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     match_found,
    output logic        [IDX_W-1:0]  match_index,
    output logic                     last,
    output logic        [CNT_W-1:0]  entry_count,
    output logic                     store_full,
    output logic                     top_valid,
    output logic signed [DATA_W-1:0] top_first,
    output logic signed [DATA_W-1:0] top_second,
    output logic signed [DATA_W-1:0] top_third,
    output logic signed [DATA_W-1:0] top_fourth,
    output logic signed [DATA_W-1:0] top_fifth
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic        [DATA_W-1:0] mem [DEPTH];
    logic        [DATA_W-1:0] rd_data_reg;

    state_t                   state_reg, state_next;
    logic        [CW-1:0]     held_count_reg;
    logic                     store_full_reg;
    logic signed [DATA_W-1:0] top_reg [TOP_COUNT];
    logic signed [DATA_W-1:0] top_next [TOP_COUNT];
    logic        [TOP_COUNT-1:0] gt;

    logic        [DATA_W-1:0] key_reg;
    logic        [CW-1:0]     rd_addr_reg;
    logic                     cmp_valid_reg;
    logic        [AW-1:0]     cmp_idx_reg;
    logic                     pend_valid_reg;
    logic        [AW-1:0]     pend_idx_reg;

    logic                     out_valid_reg;
    logic                     match_found_reg;
    logic        [IDX_W-1:0]  match_index_reg;
    logic                     last_reg;
    logic        [CNT_W-1:0]  entry_count_reg;
    logic                     store_full_out_reg;
    logic                     top_valid_reg;
    logic signed [DATA_W-1:0] top_out_reg [TOP_FIELDS];
    logic signed [DATA_W-1:0] top_snap [TOP_FIELDS];

    logic in_accept;
    logic do_append;
    logic do_search;
    logic out_free;
    logic cmp_hit;
    logic more_entries;
    logic stall;
    logic rd_en;
    logic emit_mid;
    logic emit_final;
    logic scan_end;
    logic held_enough;

    assign in_accept    = in_valid && in_ready;
    assign do_append    = in_accept && (action == ACT_APPEND);
    assign do_search    = in_accept && (action == ACT_SEARCH);
    assign out_free     = !out_valid_reg || out_ready;
    assign cmp_hit      = cmp_valid_reg && (rd_data_reg == key_reg);
    assign more_entries = rd_addr_reg < held_count_reg;
    assign stall        = cmp_hit && pend_valid_reg && !out_free;
    assign scan_end     = !cmp_valid_reg && !more_entries;
    assign held_enough  = held_count_reg >= CW'(TOP_COUNT);

    // Next state of the search sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_search)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        emit_mid   = 1'b0;
        emit_final = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en    = !stall && more_entries;
                emit_mid = cmp_hit && pend_valid_reg && out_free;
            end
            ST_DONE:
            begin
                emit_final = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Sorted insertion: the list is descending, so the slots that the new value
    // beats form a tail, and each slot of that tail shifts down by one.
    genvar g;
    generate
        for (g = 0; g < TOP_COUNT; g++)
        begin : g_top
            assign gt[g] = (held_count_reg <= CW'(g)) || (value > top_reg[g]);
            if (g == 0)
            begin : g_head
                assign top_next[g] = gt[g] ? value : top_reg[g];
            end
            else
            begin : g_tail
                assign top_next[g] = !gt[g]     ? top_reg[g]     :
                                     !gt[g - 1] ? value          : top_reg[g - 1];
            end
        end
        for (g = 0; g < TOP_FIELDS; g++)
        begin : g_snap
            if (g < TOP_COUNT)
            begin : g_used
                assign top_snap[g] = held_enough ? top_reg[g] : '0;
            end
            else
            begin : g_unused
                assign top_snap[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (do_append && (held_count_reg < CW'(DEPTH)))
        begin
            mem[held_count_reg[AW-1:0]] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            store_full_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_append)
            begin
                if (held_count_reg < CW'(DEPTH))
                begin
                    held_count_reg <= held_count_reg + 1'b1;
                end
                else
                begin
                    store_full_reg <= 1'b1;
                end
            end
            if (do_search)
            begin
                cmp_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && !stall)
            begin
                cmp_valid_reg <= rd_en;
                if (cmp_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (emit_mid || emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append && (held_count_reg < CW'(DEPTH)))
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                top_reg[i] <= top_next[i];
            end
        end
        if (do_search)
        begin
            key_reg     <= value;
            rd_addr_reg <= '0;
        end
        else if (rd_en)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            cmp_idx_reg <= rd_addr_reg[AW-1:0];
        end
        if ((state_reg == ST_SCAN) && !stall && cmp_hit)
        begin
            pend_idx_reg <= cmp_idx_reg;
        end
        if (emit_mid || emit_final)
        begin
            match_found_reg    <= emit_mid || pend_valid_reg;
            match_index_reg    <= pend_valid_reg ? IDX_W'(pend_idx_reg) : '0;
            last_reg           <= emit_final;
            entry_count_reg    <= CNT_W'(held_count_reg);
            store_full_out_reg <= store_full_reg;
            top_valid_reg      <= held_enough;
            for (int j = 0; j < TOP_FIELDS; j++)
            begin
                top_out_reg[j] <= top_snap[j];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_found = match_found_reg;
    assign match_index = match_index_reg;
    assign last        = last_reg;
    assign entry_count = entry_count_reg;
    assign store_full  = store_full_out_reg;
    assign top_valid   = top_valid_reg;
    assign top_first   = top_out_reg[0];
    assign top_second  = top_out_reg[1];
    assign top_third   = top_out_reg[2];
    assign top_fourth  = top_out_reg[3];
    assign top_fifth   = top_out_reg[4];

    a_no_match_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (match_found_reg || last_reg))
        else $error("A result without a match was not marked last.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CW'(DEPTH))
        else $error("Held count exceeds the store depth.");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(store_full_reg) |-> (held_count_reg == CW'(DEPTH)))
        else $error("Full flag set while the store had room.");

    a_pending_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && pend_valid_reg) |-> (CW'(pend_idx_reg) < held_count_reg))
        else $error("Held match index lies beyond the held entries.");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the top-five tracker with key search.
// Drives append and search words through a queue-fed driver, predicts every reply and checks
// it field by field in a clocked monitor. Depends on t5ks_pkg and top5_tracker_with_key_search.
module tb;
    import t5ks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int TOP_N       = 5;
    localparam int CYCLE_LIMIT = 500_000;

    typedef struct {
        logic                     act;
        logic signed [DATA_W-1:0] val;
    } tracker_word_t;

    typedef struct {
        logic                     found;
        logic        [IDX_W-1:0]  idx;
        logic                     lst;
        logic        [CNT_W-1:0]  cnt;
        logic                     full;
        logic                     tv;
        logic signed [DATA_W-1:0] t1;
        logic signed [DATA_W-1:0] t2;
        logic signed [DATA_W-1:0] t3;
        logic signed [DATA_W-1:0] t4;
        logic signed [DATA_W-1:0] t5;
    } search_reply_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic                     action      = ACT_APPEND;
    logic signed [DATA_W-1:0] value       = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic                     match_found;
    logic        [IDX_W-1:0]  match_index;
    logic                     last;
    logic        [CNT_W-1:0]  entry_count;
    logic                     store_full;
    logic                     top_valid;
    logic signed [DATA_W-1:0] top_first;
    logic signed [DATA_W-1:0] top_second;
    logic signed [DATA_W-1:0] top_third;
    logic signed [DATA_W-1:0] top_fourth;
    logic signed [DATA_W-1:0] top_fifth;

    tracker_word_t            words_to_send[$];
    search_reply_t            due_replies[$];
    logic signed [DATA_W-1:0] appended_values[$];
    tracker_word_t            next_word;

    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       mismatches     = 0;
    int                       cycle_count    = 0;

    int                       held_n    = 0;
    logic                     dropped_q = 1'b0;
    logic signed [DATA_W-1:0] store_copy [DEPTH];
    logic signed [DATA_W-1:0] top_copy [TOP_N];

    top5_tracker_with_key_search #(
        .DEPTH     (DEPTH),
        .TOP_COUNT (TOP_N)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_found (match_found),
        .match_index (match_index),
        .last        (last),
        .entry_count (entry_count),
        .store_full  (store_full),
        .top_valid   (top_valid),
        .top_first   (top_first),
        .top_second  (top_second),
        .top_third   (top_third),
        .top_fourth  (top_fourth),
        .top_fifth   (top_fifth)
    );

    always #1 clk = ~clk;

    function automatic search_reply_t snapshot(logic found, logic [IDX_W-1:0] idx, logic lst);
        search_reply_t r;
        r.found = found;
        r.idx   = idx;
        r.lst   = lst;
        r.cnt   = CNT_W'(held_n);
        r.full  = dropped_q;
        r.tv    = (held_n >= TOP_N);
        r.t1    = r.tv ? top_copy[0] : '0;
        r.t2    = r.tv ? top_copy[1] : '0;
        r.t3    = r.tv ? top_copy[2] : '0;
        r.t4    = r.tv ? top_copy[3] : '0;
        r.t5    = r.tv ? top_copy[4] : '0;
        return r;
    endfunction

    task automatic track_word(input logic act, input logic signed [DATA_W-1:0] v);
        int            filled;
        int            pos;
        bit            have_held;
        search_reply_t held_reply;
        have_held = 1'b0;
        if (act == ACT_APPEND)
        begin
            if (held_n >= DEPTH)
            begin
                dropped_q = 1'b1;
            end
            else
            begin
                filled = (held_n < TOP_N) ? held_n : TOP_N;
                pos = 0;
                while (pos < filled && !(v > top_copy[pos]))
                    pos++;
                if (pos < TOP_N)
                begin
                    for (int i = TOP_N - 1; i > pos; i--)
                        top_copy[i] = top_copy[i - 1];
                    top_copy[pos] = v;
                end
                store_copy[held_n] = v;
                held_n++;
            end
        end
        else
        begin
            for (int i = 0; i < held_n; i++)
            begin
                if (store_copy[i] == v)
                begin
                    if (have_held)
                        due_replies.insert(due_replies.size(), held_reply);
                    held_reply = snapshot(1'b1, IDX_W'(i), 1'b0);
                    have_held = 1'b1;
                end
            end
            if (have_held)
            begin
                held_reply.lst = 1'b1;
                due_replies.insert(due_replies.size(), held_reply);
            end
            else
            begin
                due_replies.insert(due_replies.size(), snapshot(1'b0, '0, 1'b1));
            end
        end
    endtask

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= ACT_APPEND;
            value    <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = words_to_send.pop_front();
                in_valid <= 1'b1;
                action   <= next_word.act;
                value    <= next_word.val;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        search_reply_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_replies.size() == 0)
                begin
                    $display("%0t: reply with no search waiting, match_index %0d",
                             $time, match_index);
                    mismatches++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    check_field("match_found", DATA_W'(want.found), DATA_W'(match_found));
                    check_field("match_index", DATA_W'(want.idx), DATA_W'(match_index));
                    check_field("last", DATA_W'(want.lst), DATA_W'(last));
                    check_field("entry_count", DATA_W'(want.cnt), DATA_W'(entry_count));
                    check_field("store_full", DATA_W'(want.full), DATA_W'(store_full));
                    check_field("top_valid", DATA_W'(want.tv), DATA_W'(top_valid));
                    check_field("top_first", want.t1, top_first);
                    check_field("top_second", want.t2, top_second);
                    check_field("top_third", want.t3, top_third);
                    check_field("top_fourth", want.t4, top_fourth);
                    check_field("top_fifth", want.t5, top_fifth);
                end
            end
            if (in_valid && in_ready)
                track_word(action, value);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d replies outstanding", $time, due_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pooled_value(int k);
        case (k)
            0: return 7;
            1: return -7;
            2: return 100;
            3: return 32'sh8000_0000;
            4: return 32'sh7fff_ffff;
            default: return 0;
        endcase
    endfunction

    task automatic add_word(input logic act, input logic signed [DATA_W-1:0] v);
        tracker_word_t w;
        w.act = act;
        w.val = v;
        words_to_send.insert(words_to_send.size(), w);
        if (act == ACT_APPEND)
            appended_values.insert(appended_values.size(), v);
    endtask

    task automatic make_random_words(input int n);
        int                       pick;
        logic signed [DATA_W-1:0] v;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 40)
            begin
                if (pick < 40)
                    v = pooled_value($urandom_range(5));
                else if (pick < 50)
                    v = -1;
                else
                    v = $urandom;
                add_word(ACT_APPEND, v);
            end
            else
            begin
                if (pick < 55 && appended_values.size() > 0)
                    v = appended_values[$urandom_range(appended_values.size() - 1)];
                else if (pick < 70)
                    v = pooled_value($urandom_range(5));
                else
                    v = $urandom;
                add_word(ACT_SEARCH, v);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || in_valid || due_replies.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        make_random_words(n);
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_word(ACT_SEARCH, 0);
        add_word(ACT_APPEND, 32'sh7fff_ffff);
        add_word(ACT_APPEND, 32'sh8000_0000);
        add_word(ACT_SEARCH, 32'sh8000_0000);
        add_word(ACT_APPEND, 0);
        add_word(ACT_APPEND, -1);
        add_word(ACT_SEARCH, 5);
        add_word(ACT_APPEND, -1);
        add_word(ACT_SEARCH, -1);
        add_word(ACT_APPEND, 32'sh7fff_ffff);
        add_word(ACT_APPEND, 32'sh8000_0000);
        add_word(ACT_APPEND, 1);
        add_word(ACT_SEARCH, 32'sh7fff_ffff);
        add_word(ACT_SEARCH, 32'sh8000_0000);
        add_word(ACT_SEARCH, 0);
        add_word(ACT_APPEND, 32'sh5555_5555);
        add_word(ACT_APPEND, 32'shaaaa_aaaa);
        add_word(ACT_SEARCH, 32'shaaaa_aaaa);
        add_word(ACT_SEARCH, 32'sh5555_5555);
        wait_drained();

        run_phase(0, 0, 60);
        run_phase(74, 0, 60);
        run_phase(0, 74, 60);
        run_phase(10, 10, 60);

        repeat (DEPTH + 10) @(posedge clk);
        if (mismatches == 0 && due_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
